// ===== hw/rtl/csd_pkg.sv =====
// shared types, constants and the color letter decode for the sprite decoder
package csd_pkg;

    // default parameter values
    localparam int COORD_WIDTH_DEF = 12;
    localparam int ADDR_WIDTH_DEF  = 24;

    // configuration register widths and port format
    localparam int ORIGIN_W    = 12;
    localparam int PITCH_W     = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CODE_W      = 8;
    localparam int COLOR_W     = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_PITCH = 2'd2;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd320;

    // sprite code characters
    localparam logic [CODE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CODE_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CODE_W-1:0] CH_STAR  = 8'h2a;
    localparam logic [CODE_W-1:0] CH_LO_R  = 8'h72;
    localparam logic [CODE_W-1:0] CH_LO_G  = 8'h67;
    localparam logic [CODE_W-1:0] CH_LO_Y  = 8'h79;
    localparam logic [CODE_W-1:0] CH_LO_B  = 8'h62;
    localparam logic [CODE_W-1:0] CH_LO_P  = 8'h70;
    localparam logic [CODE_W-1:0] CH_LO_L  = 8'h6c;
    localparam logic [CODE_W-1:0] CH_LO_W  = 8'h77;
    localparam logic [CODE_W-1:0] CH_DASH  = 8'h2d;
    localparam logic [CODE_W-1:0] CH_UP_R  = 8'h52;
    localparam logic [CODE_W-1:0] CH_UP_G  = 8'h47;
    localparam logic [CODE_W-1:0] CH_UP_Y  = 8'h59;
    localparam logic [CODE_W-1:0] CH_UP_B  = 8'h42;
    localparam logic [CODE_W-1:0] CH_UP_P  = 8'h50;
    localparam logic [CODE_W-1:0] CH_LO_S  = 8'h73;
    localparam logic [CODE_W-1:0] CH_EQUAL = 8'h3d;

    // configuration register set
    typedef struct packed {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [PITCH_W-1:0]  line_pitch;
    } cfg_t;

    // per-word control carried from the decode stage to the address stage
    typedef struct packed {
        logic               write_pixel;
        logic [COLOR_W-1:0] color;
        logic               done;
    } pix_ctrl_t;

    // color letter lookup: bit 4 is the hit flag, bits 3:0 the palette index
    function automatic logic [COLOR_W:0] letter_color(input logic [CODE_W-1:0] ch);
        logic [COLOR_W:0] res;
        case (ch)
            CH_STAR:  res = {1'b1, 4'd0};
            CH_LO_R:  res = {1'b1, 4'd1};
            CH_LO_G:  res = {1'b1, 4'd2};
            CH_LO_Y:  res = {1'b1, 4'd3};
            CH_LO_B:  res = {1'b1, 4'd4};
            CH_LO_P:  res = {1'b1, 4'd5};
            CH_LO_L:  res = {1'b1, 4'd6};
            CH_LO_W:  res = {1'b1, 4'd7};
            CH_DASH:  res = {1'b1, 4'd8};
            CH_UP_R:  res = {1'b1, 4'd9};
            CH_UP_G:  res = {1'b1, 4'd10};
            CH_UP_Y:  res = {1'b1, 4'd11};
            CH_UP_B:  res = {1'b1, 4'd12};
            CH_UP_P:  res = {1'b1, 4'd13};
            CH_LO_S:  res = {1'b1, 4'd14};
            CH_EQUAL: res = {1'b1, 4'd15};
            default:  res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/csd_cfg.sv =====
// configuration registers for origin and line pitch
module csd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [csd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [csd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output csd_pkg::cfg_t                    cfg
);
    import csd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_ORIGIN_X:   cfg_next.origin_x   = cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:   cfg_next.origin_y   = cfg_data[ORIGIN_W-1:0];
                REG_LINE_PITCH: cfg_next.line_pitch = cfg_data[PITCH_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.line_pitch <= PITCH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/csd_front.sv =====
// decode stage: line and column tracking, letter decode, input register
module csd_front #(
    parameter int COORD_WIDTH = csd_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  csd_pkg::cfg_t                        cfg,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [csd_pkg::CODE_W-1:0]           code_char,
    input  logic                                 advance,
    output logic                                 s1_valid,
    output csd_pkg::pix_ctrl_t                   s1_ctrl,
    output logic [((COORD_WIDTH > csd_pkg::ORIGIN_W) ? COORD_WIDTH
                   : csd_pkg::ORIGIN_W):0]       s1_row_sum,
    output logic [((COORD_WIDTH > csd_pkg::ORIGIN_W) ? COORD_WIDTH
                   : csd_pkg::ORIGIN_W):0]       s1_col_sum
);
    import csd_pkg::*;

    localparam int SUM_W = ((COORD_WIDTH > ORIGIN_W) ? COORD_WIDTH : ORIGIN_W) + 1;

    logic [COORD_WIDTH-1:0] line_reg, line_next;
    logic [COORD_WIDTH-1:0] column_reg, column_next;
    logic                   pending_reg, pending_next;
    logic                   s1_valid_reg, s1_valid_next;
    pix_ctrl_t              ctrl_reg, ctrl_next;
    logic [SUM_W-1:0]       row_sum_reg, row_sum_next;
    logic [SUM_W-1:0]       col_sum_reg, col_sum_next;
    logic [COLOR_W:0]       lookup;
    logic                   accept;

    // handshake: hold while the stage is full and cannot drain
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign lookup = letter_color(code_char);

    // next position state and the word's control
    always_comb
    begin
        line_next    = line_reg;
        column_next  = column_reg;
        pending_next = pending_reg;
        ctrl_next    = '0;
        if (code_char == CH_NUL)
        begin
            if (pending_reg)
            begin
                ctrl_next.done = 1'b1;
                line_next      = '0;
                column_next    = '0;
                pending_next   = 1'b0;
            end
            else
            begin
                line_next    = line_reg + 1'b1;
                column_next  = '0;
                pending_next = 1'b1;
            end
        end
        else
        begin
            // dot and unknown bytes only advance the column
            pending_next          = 1'b0;
            column_next           = column_reg + 1'b1;
            ctrl_next.write_pixel = lookup[COLOR_W];
            ctrl_next.color       = lookup[COLOR_W] ? lookup[COLOR_W-1:0] : '0;
        end
    end

    // row and column sums for the address stage, from the position before update
    assign row_sum_next = SUM_W'(cfg.origin_y) + SUM_W'(line_reg);
    assign col_sum_next = SUM_W'(cfg.origin_x) + SUM_W'(column_reg);

    // stage valid
    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg     <= '0;
            column_reg   <= '0;
            pending_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                line_reg    <= line_next;
                column_reg  <= column_next;
                pending_reg <= pending_next;
            end
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctrl_reg    <= ctrl_next;
            row_sum_reg <= row_sum_next;
            col_sum_reg <= col_sum_next;
        end
    end

    assign s1_valid   = s1_valid_reg;
    assign s1_ctrl    = ctrl_reg;
    assign s1_row_sum = row_sum_reg;
    assign s1_col_sum = col_sum_reg;

endmodule

// ===== hw/rtl/csd_addr.sv =====
// address stage: row times pitch plus column, result register
module csd_addr #(
    parameter int COORD_WIDTH = csd_pkg::COORD_WIDTH_DEF,
    parameter int ADDR_WIDTH  = csd_pkg::ADDR_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  csd_pkg::cfg_t                        cfg,
    input  logic                                 s1_valid,
    input  csd_pkg::pix_ctrl_t                   s1_ctrl,
    input  logic [((COORD_WIDTH > csd_pkg::ORIGIN_W) ? COORD_WIDTH
                   : csd_pkg::ORIGIN_W):0]       s1_row_sum,
    input  logic [((COORD_WIDTH > csd_pkg::ORIGIN_W) ? COORD_WIDTH
                   : csd_pkg::ORIGIN_W):0]       s1_col_sum,
    output logic                                 advance,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 write_pixel,
    output logic [ADDR_WIDTH-1:0]                pixel_addr,
    output logic [csd_pkg::COLOR_W-1:0]          pixel_color,
    output logic                                 picture_done
);
    import csd_pkg::*;

    localparam int SUM_W  = ((COORD_WIDTH > ORIGIN_W) ? COORD_WIDTH : ORIGIN_W) + 1;
    localparam int PROD_W = SUM_W + PITCH_W;
    localparam int FULL_W = ((ADDR_WIDTH > PROD_W) ? ADDR_WIDTH : PROD_W) + 1;

    logic                  out_valid_reg, out_valid_next;
    pix_ctrl_t             ctrl_reg;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic [PROD_W-1:0]     product;
    logic [FULL_W-1:0]     full_sum;
    logic                  load;

    // output register frees when empty or being taken
    assign advance = !out_valid_reg || !out_stall;
    assign load    = s1_valid && advance;

    // row base times pitch, plus column, wrapped to the address width
    assign product   = PROD_W'(s1_row_sum) * PROD_W'(cfg.line_pitch);
    assign full_sum  = FULL_W'(product) + FULL_W'(s1_col_sum);
    assign addr_next = s1_ctrl.write_pixel ? full_sum[ADDR_WIDTH-1:0] : '0;

    assign out_valid_next = advance ? s1_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctrl_reg <= s1_ctrl;
            addr_reg <= addr_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_pixel  = ctrl_reg.write_pixel;
    assign pixel_addr   = addr_reg;
    assign pixel_color  = ctrl_reg.color;
    assign picture_done = ctrl_reg.done;

endmodule

// ===== hw/rtl/char_art_sprite_decoder.sv =====
// Character-art sprite decoder: takes one sprite code byte per word and returns one
// framebuffer write word per byte. Color letters write a palette index at
// (origin_y+line)*line_pitch+origin_x+column, '.' and unknown bytes only step the column,
// one NUL ends the line and a second NUL in a row ends the picture with picture_done.
// Throughput is one byte per clock when the output is not stalled; a byte goes through
// letter decode, position update and the row and column sums ahead of the input register,
// then the row-times-pitch multiply and add between it and the result register.
// A stalled output holds up to two words inside before in_stall rises.
// Write origin and pitch registers only while no words are in flight.
module char_art_sprite_decoder #(
    parameter int COORD_WIDTH = csd_pkg::COORD_WIDTH_DEF,
    parameter int ADDR_WIDTH  = csd_pkg::ADDR_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [csd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [csd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [csd_pkg::CODE_W-1:0]       code_char,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             write_pixel,
    output logic [ADDR_WIDTH-1:0]            pixel_addr,
    output logic [csd_pkg::COLOR_W-1:0]      pixel_color,
    output logic                             picture_done
);
    import csd_pkg::*;

    localparam int SUM_W = ((COORD_WIDTH > ORIGIN_W) ? COORD_WIDTH : ORIGIN_W) + 1;

    cfg_t             cfg;
    logic             advance;
    logic             s1_valid;
    pix_ctrl_t        s1_ctrl;
    logic [SUM_W-1:0] s1_row_sum;
    logic [SUM_W-1:0] s1_col_sum;

    // configuration registers
    csd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // decode and position stage
    csd_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_char  (code_char),
        .advance    (advance),
        .s1_valid   (s1_valid),
        .s1_ctrl    (s1_ctrl),
        .s1_row_sum (s1_row_sum),
        .s1_col_sum (s1_col_sum)
    );

    // address and result stage
    csd_addr #(
        .COORD_WIDTH (COORD_WIDTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .s1_valid     (s1_valid),
        .s1_ctrl      (s1_ctrl),
        .s1_row_sum   (s1_row_sum),
        .s1_col_sum   (s1_col_sum),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_pixel  (write_pixel),
        .pixel_addr   (pixel_addr),
        .pixel_color  (pixel_color),
        .picture_done (picture_done)
    );

endmodule

// ===== tb/char_art_sprite_decoder_checker.sv =====
`timescale 1ns / 1ps
// checker for the sprite decoder: tracks config writes, predicts each output word and compares
module char_art_sprite_decoder_checker #(
    parameter int COORD_W = csd_pkg::COORD_WIDTH_DEF,
    parameter int ADDR_W  = csd_pkg::ADDR_WIDTH_DEF,
    // palette letters, index 0 in the low byte
    parameter logic [16*csd_pkg::CODE_W-1:0] PALETTE_CODES = '0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [csd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [csd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [csd_pkg::CODE_W-1:0]      code_char,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            write_pixel,
    input  logic [ADDR_W-1:0]               pixel_addr,
    input  logic [csd_pkg::COLOR_W-1:0]     pixel_color,
    input  logic                            picture_done,
    output int                              fail_count,
    output int                              words_pending
);
    import csd_pkg::*;

    localparam int MAX_PRINTED = 30;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic               wr;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               done;
    } pixel_word_t;

    // register copies
    logic [ORIGIN_W-1:0] org_x = '0;
    logic [ORIGIN_W-1:0] org_y = '0;
    logic [PITCH_W-1:0]  pitch = PITCH_RESET;

    // sprite position
    logic [COORD_W-1:0] line_pos = '0;
    logic [COORD_W-1:0] col_pos  = '0;
    logic               nul_seen = 1'b0;

    pixel_word_t expected_words[$];

    task automatic report_mismatch(input string what, input logic [CODE_W-1:0] code,
                                   input logic [31:0] got, input logic [31:0] want);
        if (fail_count < MAX_PRINTED)
            $display("mismatch: %0s for byte %02h, got %0h, expected %0h",
                     what, code, got, want);
        fail_count++;
    endtask

    // advance the sprite position by one code byte and build the word it should produce
    function automatic pixel_word_t decode_code(input logic [CODE_W-1:0] ch);
        pixel_word_t w;
        logic [4:0]  idx;
        logic [63:0] row;
        logic [63:0] offset;
        w = '0;
        w.code = ch;
        if (ch == CH_NUL) begin
            if (nul_seen) begin
                // second NUL in a row closes the picture
                w.done   = 1'b1;
                line_pos = '0;
                col_pos  = '0;
                nul_seen = 1'b0;
            end else begin
                line_pos = line_pos + 1'b1;
                col_pos  = '0;
                nul_seen = 1'b1;
            end
        end else begin
            nul_seen = 1'b0;
            for (idx = 5'd0; idx < 5'd16; idx++) begin
                if (ch == PALETTE_CODES[idx*CODE_W +: CODE_W]) begin
                    w.wr    = 1'b1;
                    w.color = idx[COLOR_W-1:0];
                end
            end
            if (w.wr) begin
                row    = org_y;
                row    = row + line_pos;
                offset = row * pitch + org_x + col_pos;
                w.addr = offset[ADDR_W-1:0];
            end
            // dots and unknown bytes step the column as well
            col_pos = col_pos + 1'b1;
        end
        return w;
    endfunction

    // watch config port and both channels
    always @(posedge clk or negedge rst_n) begin
        pixel_word_t want;
        if (!rst_n) begin
            org_x    = '0;
            org_y    = '0;
            pitch    = PITCH_RESET;
            line_pos = '0;
            col_pos  = '0;
            nul_seen = 1'b0;
            expected_words.delete();
            words_pending <= 0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_ORIGIN_X:   org_x = cfg_data[ORIGIN_W-1:0];
                    REG_ORIGIN_Y:   org_y = cfg_data[ORIGIN_W-1:0];
                    REG_LINE_PITCH: pitch = cfg_data[PITCH_W-1:0];
                    default:        ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("output word with nothing expected", '0, 32'd1, 32'd0);
                end else begin
                    want = expected_words.pop_front();
                    if (write_pixel !== want.wr)
                        report_mismatch("write_pixel", want.code, 32'(write_pixel),
                                        32'(want.wr));
                    if (pixel_addr !== want.addr)
                        report_mismatch("pixel_addr", want.code, 32'(pixel_addr),
                                        32'(want.addr));
                    if (pixel_color !== want.color)
                        report_mismatch("pixel_color", want.code, 32'(pixel_color),
                                        32'(want.color));
                    if (picture_done !== want.done)
                        report_mismatch("picture_done", want.code, 32'(picture_done),
                                        32'(want.done));
                end
            end
            if (in_valid && !in_stall)
                expected_words.push_back(decode_code(code_char));
            words_pending <= expected_words.size();
        end
    end

endmodule

// ===== tb/char_art_sprite_decoder_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the sprite decoder: drives code bytes and config, stalls the output, gives the verdict
module char_art_sprite_decoder_tb;
    import csd_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_BYTES    = 500;
    localparam int RANDOM_SETTINGS = 10;
    localparam int WRAP_SPAN       = 24;
    localparam int TAIL_CYCLES     = 8;

    // palette order, index 0 in the low byte
    localparam logic [16*CODE_W-1:0] PALETTE_CODES = {
        CH_EQUAL, CH_LO_S, CH_UP_P, CH_UP_B, CH_UP_Y, CH_UP_G, CH_UP_R, CH_DASH,
        CH_LO_W, CH_LO_L, CH_LO_P, CH_LO_B, CH_LO_Y, CH_LO_G, CH_LO_R, CH_STAR
    };

    logic                            clk;
    logic                            rst_n      = 1'b0;
    logic                            cfg_write  = 1'b0;
    logic [CFG_INDEX_W-1:0]          cfg_index  = '0;
    logic [CFG_DATA_W-1:0]           cfg_data   = '0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic [CODE_W-1:0]               code_char  = '0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic                            write_pixel;
    logic [ADDR_WIDTH_DEF-1:0]       pixel_addr;
    logic [COLOR_W-1:0]              pixel_color;
    logic                            picture_done;

    int fail_count;
    int words_pending;
    int cycle_count    = 0;
    int burst_left     = 0;
    int bytes_sent     = 0;
    int sprites_sent   = 0;
    int settings_used  = 0;
    int stall_mode     = 0;
    int stall_left     = 0;

    char_art_sprite_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_char    (code_char),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_pixel  (write_pixel),
        .pixel_addr   (pixel_addr),
        .pixel_color  (pixel_color),
        .picture_done (picture_done)
    );

    char_art_sprite_decoder_checker #(
        .PALETTE_CODES (PALETTE_CODES)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .code_char     (code_char),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_pixel   (write_pixel),
        .pixel_addr    (pixel_addr),
        .pixel_color   (pixel_color),
        .picture_done  (picture_done),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // output stall: free-running, sparse random, dense random or a fixed 5-of-8 pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(4, 40);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ((stall_left % 8) < 5);
        endcase
    end

    function automatic logic [CODE_W-1:0] palette_letter(input int idx);
        return PALETTE_CODES[idx*CODE_W +: CODE_W];
    endfunction

    // any byte but NUL: mostly letters, some dots, a few unknown bytes
    function automatic logic [CODE_W-1:0] sprite_filler();
        int pick;
        int raw;
        pick = $urandom_range(0, 99);
        raw  = $urandom_range(1, 255);
        if (pick < 70)
            return palette_letter($urandom_range(0, 15));
        else if (pick < 92)
            return CH_DOT;
        return raw[CODE_W-1:0];
    endfunction

    // one word on the input channel, with burst gaps in between
    task automatic send_code(input logic [CODE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        code_char <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left = burst_left - 1;
        bytes_sent = bytes_sent + 1;
    endtask

    // stop sending and wait for every outstanding word
    task automatic drain_words();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (words_pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // origins carry a random top bit that the block must drop
    task automatic apply_setting(input int ox, input int oy, input int lp);
        logic [CFG_DATA_W-1:0] d;
        drain_words();
        d = ox[CFG_DATA_W-1:0];
        d[CFG_DATA_W-1] = ($urandom_range(0, 1) == 1);
        write_reg(REG_ORIGIN_X, d);
        d = oy[CFG_DATA_W-1:0];
        d[CFG_DATA_W-1] = ($urandom_range(0, 1) == 1);
        write_reg(REG_ORIGIN_Y, d);
        write_reg(REG_LINE_PITCH, lp[CFG_DATA_W-1:0]);
        settings_used = settings_used + 1;
    endtask

    // well-formed sprite: lines closed by NUL, picture closed by a second NUL
    task automatic send_sprite();
        int lines;
        int len;
        int k;
        int j;
        lines = $urandom_range(1, 5);
        for (k = 0; k < lines; k++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            for (j = 0; j < len; j++)
                send_code(sprite_filler());
            send_code(CH_NUL);
        end
        send_code(CH_NUL);
        sprites_sent = sprites_sent + 1;
    endtask

    // short burst of arbitrary bytes, NUL-heavy
    task automatic send_noise();
        int n;
        int k;
        int raw;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
        begin
            raw = $urandom_range(0, 255);
            send_code(($urandom_range(0, 2) == 0) ? CH_NUL : raw[CODE_W-1:0]);
        end
    endtask

    function automatic int random_origin();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int random_pitch();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return $urandom_range(4097, 8191);
            2: return 1;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    // main sequence
    initial
    begin
        int k;
        int target;
        int ox;
        int oy;
        int lp;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: whole palette, dot, unknown bytes, line end, picture end at reset setting
        for (k = 0; k < 16; k++)
            send_code(palette_letter(k));
        send_code(CH_DOT);
        send_code(8'hff);
        send_code(8'h80);
        send_code(CH_NUL);
        send_code(CH_LO_W);
        send_code(CH_NUL);
        send_code(CH_NUL);
        send_code(8'h01);
        send_code(CH_NUL);
        settings_used = 1;

        // random sprites over several settings, extremes first
        for (k = 0; k < RANDOM_SETTINGS; k++)
        begin
            case (k)
                0: begin ox = 4095; oy = 4095; lp = 8191; end
                1: begin ox = 0;    oy = 0;    lp = 0;    end
                2: begin ox = 0;    oy = 4095; lp = 4096; end
                3: begin ox = 4095; oy = 0;    lp = 1;    end
                default:
                begin
                    ox = random_origin();
                    oy = random_origin();
                    lp = random_pitch();
                end
            endcase
            apply_setting(ox, oy, lp);
            target = bytes_sent + RANDOM_BYTES / RANDOM_SETTINGS;
            while (bytes_sent < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    send_sprite();
                if ($urandom_range(0, 9) == 0)
                    drain_words();
            end
        end

        // largest origins and pitch so the address wraps on every written line
        apply_setting(4095, 4095, 8191);
        for (k = 0; k < WRAP_SPAN; k++)
            send_code(($urandom_range(0, 7) == 0) ? CH_DOT
                                                  : palette_letter($urandom_range(0, 15)));
        for (k = 0; k < WRAP_SPAN; k++)
        begin
            send_code(CH_NUL);
            send_code(($urandom_range(0, 7) == 0) ? CH_DOT
                                                  : palette_letter($urandom_range(0, 15)));
        end
        send_code(CH_NUL);
        send_code(CH_NUL);

        drain_words();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d code bytes, %0d random sprites, %0d register settings",
                 bytes_sent, sprites_sent, settings_used);
        $display("incl. full palette, unknown bytes, zero pitch and address wrap");
        if (fail_count == 0 && words_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
